// ----- rtl/okvt_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered key/value table package
// Sizes, operation and status codes, and the control and result structs that
// the top level and the table cells share.
// ----------------------------------------------------------------------------
package okvt_pkg;

  // Number of pairs that the table holds.
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_FIND   = 2'd1,
    OP_UPDATE = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Operation broadcast to every cell in the cycle that a beat is taken.
  typedef struct packed {
    logic               fire;
    op_t                op;
    logic [DATA_W-1:0]  key;
    logic [DATA_W-1:0]  value;
    logic [COUNT_W-1:0] count;
    logic               full;
  } okvt_ctrl_t;

  // Pair reported by the first matching cell, zero elsewhere.
  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } okvt_res_t;

endpackage

// ----- rtl/okvt_cell.sv -----
// ----------------------------------------------------------------------------
// Ordered key/value table cell
// Holds one pair, compares it with the broadcast key and shifts towards the
// back on push or towards the front on remove.
// ----------------------------------------------------------------------------
module okvt_cell (
  input  logic                                  clk,
  input  okvt_pkg::okvt_ctrl_t                  ctrl,
  input  logic [okvt_pkg::IDX_W-1:0]            idx,
  input  logic [okvt_pkg::DATA_W-1:0]           prev_key,
  input  logic [okvt_pkg::DATA_W-1:0]           prev_value,
  input  logic [okvt_pkg::DATA_W-1:0]           next_key,
  input  logic [okvt_pkg::DATA_W-1:0]           next_value,
  input  logic                                  hit_in,
  output logic                                  hit_out,
  input  okvt_pkg::okvt_res_t                   res_in,
  output okvt_pkg::okvt_res_t                   res_out,
  output logic [okvt_pkg::DATA_W-1:0]           key_q,
  output logic [okvt_pkg::DATA_W-1:0]           value_q
);
  import okvt_pkg::*;

  logic              occupied;
  logic              match_here;
  logic              first;
  logic [DATA_W-1:0] value_inc;
  okvt_res_t         mine;

  // Match detection with priority to the front of the table.
  assign occupied   = COUNT_W'(idx) < ctrl.count;
  assign match_here = occupied && (key_q == ctrl.key) && (ctrl.op != OP_PUSH);
  assign first      = match_here && !hit_in;
  assign hit_out    = hit_in || match_here;
  assign value_inc  = value_q + DATA_W'(1);

  // Report this pair when it is the first match of a find or remove.
  always_comb begin
    mine = '0;
    if (first && (ctrl.op == OP_FIND)) begin
      mine.key   = key_q;
      mine.value = value_inc;
    end else if (first && (ctrl.op == OP_REMOVE)) begin
      mine.key   = key_q;
      mine.value = value_q;
    end
  end

  assign res_out = res_in | mine;

  // Storage update for the operation in flight.
  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      unique case (ctrl.op)
        OP_PUSH: begin
          if (!ctrl.full) begin
            key_q   <= prev_key;
            value_q <= prev_value;
          end
        end
        OP_FIND: begin
          if (first) begin
            value_q <= value_inc;
          end
        end
        OP_UPDATE: begin
          if (first) begin
            value_q <= ctrl.value;
          end
        end
        OP_REMOVE: begin
          if (hit_out) begin
            key_q   <= next_key;
            value_q <= next_value;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/ordered_key_value_table_core.sv -----
// ----------------------------------------------------------------------------
// Ordered key/value table core
// Front-ordered table of key/value pairs kept in a row of cells, with push,
// find (with increment), update and remove of the first match.
//
// Channel  Handshake            Payload
// in       in_valid, in_stall   operation, key, entry_value
// out      out_valid, out_stall status, out_key, out_value
//
// Every beat is worked by all cells at once: each compares, and the first
// match from the front is picked along the cell row. The result sits in an
// output register, so one beat a cycle is taken while results are drained.
// in_stall is high only while a result waits and out_stall holds it.
// Reset empties the table; stored pairs are not cleared.
// ----------------------------------------------------------------------------
module ordered_key_value_table_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         operation,
  input  logic signed [okvt_pkg::DATA_W-1:0] key,
  input  logic signed [okvt_pkg::DATA_W-1:0] entry_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic signed [okvt_pkg::DATA_W-1:0] out_key,
  output logic signed [okvt_pkg::DATA_W-1:0] out_value
);
  import okvt_pkg::*;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               fire;
  logic               full;
  op_t                op;
  okvt_ctrl_t         ctrl;
  status_t            status_next;

  logic      [DATA_W-1:0] cell_key   [TABLE_DEPTH];
  logic      [DATA_W-1:0] cell_value [TABLE_DEPTH];
  logic                   hit_chain  [TABLE_DEPTH+1];
  okvt_res_t              res_chain  [TABLE_DEPTH+1];

  // Input handshake and broadcast control.
  assign in_stall = out_valid && out_stall;
  assign fire     = in_valid && !in_stall;
  assign op       = op_t'(operation);
  assign full     = (count == COUNT_W'(TABLE_DEPTH));

  assign ctrl.fire  = fire;
  assign ctrl.op    = op;
  assign ctrl.key   = key;
  assign ctrl.value = entry_value;
  assign ctrl.count = count;
  assign ctrl.full  = full;

  assign hit_chain[0] = 1'b0;
  assign res_chain[0] = '0;

  // Row of cells, front at index zero.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] pk, pv, nk, nv;
    if (i == 0) begin : g_front
      assign pk = key;
      assign pv = entry_value;
    end else begin : g_inner_p
      assign pk = cell_key[i-1];
      assign pv = cell_value[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_back
      assign nk = cell_key[i];
      assign nv = cell_value[i];
    end else begin : g_inner_n
      assign nk = cell_key[i+1];
      assign nv = cell_value[i+1];
    end

    okvt_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (IDX_W'(i)),
      .prev_key   (pk),
      .prev_value (pv),
      .next_key   (nk),
      .next_value (nv),
      .hit_in     (hit_chain[i]),
      .hit_out    (hit_chain[i+1]),
      .res_in     (res_chain[i]),
      .res_out    (res_chain[i+1]),
      .key_q      (cell_key[i]),
      .value_q    (cell_value[i])
    );
  end

  // Status and fill count for the beat in flight.
  always_comb begin
    count_next  = count;
    status_next = ST_MISS;
    if (op == OP_PUSH) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_OK;
        count_next  = count + COUNT_W'(1);
      end
    end else if (hit_chain[TABLE_DEPTH]) begin
      status_next = ST_OK;
      if (op == OP_REMOVE) begin
        count_next = count - COUNT_W'(1);
      end
    end
  end

  // Fill count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        count <= count_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (fire) begin
      status    <= status_next;
      out_key   <= res_chain[TABLE_DEPTH].key;
      out_value <= res_chain[TABLE_DEPTH].value;
    end
  end

  // Checks on the design's own logic.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(TABLE_DEPTH))
    else $error("fill count exceeds table depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> full)
    else $error("full status reported while the table is not full");

  a_refused_push: assert property (@(posedge clk) disable iff (rst)
    fire && (op == OP_PUSH) && full |=> count == $past(count))
    else $error("refused push changed the fill count");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule
